// ===== hdl/pbsd_pkg.sv =====
package pbsd_pkg;

    localparam int DIM_BITS = 12;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PACKED_MODE  = 2'd2;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd320;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd200;
    localparam logic [DIM_BITS-1:0] WIDTH_MIN    = 12'd4;

    localparam logic [7:0] NOOP_HEADER = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0]          color;
        logic [DIM_BITS-1:0] span_x;
        logic [DIM_BITS-1:0] span_row;
        logic [7:0]          span_length;
        logic                last_of_item;
        logic                frame_done;
        logic                overrun;
    } t_out_item;

    typedef struct packed {
        logic accept;   // take the input item and decode it
        logic emit;     // load one span into the output register
    } t_cmd;

    typedef struct packed {
        logic pending;    // a span or overrun result is still owed
        logic span_last;  // the span offered now is the last of the item
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

// ===== hdl/packbits_pixel_span_decoder.sv =====
// packbits pixel span decoder: takes an 8-bit chunky image body one byte per item
// and reports the pixels it places as spans (color, start column, row, length),
// split at row ends so rows wrap pixel by pixel. with packed_mode set the body is
// packbits: a header below 0x80 opens a literal of header+1 bytes, a header above
// 0x80 repeats the next byte 257-header times, 0x80 is a no-op; with it clear each
// byte is one pixel. frame_start on an item clears position and decoder phase
// first. bytes after the last row give one overrun result each. headers and
// no-ops give no result; a pixel byte gives one span, plus one further span for
// each row end its run crosses, from the span loop that emits one span per cycle
// into the output register while that register is free or being read. a new
// byte is taken once the last span of the previous byte is in the output
// register, even while that span waits to be taken. configuration writes are
// always accepted and must only be made while the block is idle.
module packbits_pixel_span_decoder
    import pbsd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in,
    // span output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // config registers never stall
    assign o_cfg_ready = 1'b1;

    // sequencer: idle / emit spans
    pbsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // decoder state, position counters, span splitter and output register
    pbsd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/pbsd_ctrl.sv =====
module pbsd_ctrl
    import pbsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    assign o_in_ready   = r_in_ready;
    assign o_cmd.accept = i_in_valid & r_in_ready;
    assign o_cmd.emit   = (r_state == S_EMIT) & i_status.pending & i_status.out_free;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state    = S_EMIT;
                    n_in_ready = 1'b0;
                end
            end
            S_EMIT: begin
                if (!i_status.pending || (o_cmd.emit && i_status.span_last)) begin
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !r_in_ready)
        else $error("input ready while spans are being emitted");

endmodule

// ===== hdl/pbsd_dpath.sv =====
module pbsd_dpath
    import pbsd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  t_in_item                i_in,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out
);

    logic [DIM_BITS-1:0] r_width, r_height;
    logic                r_packed;

    t_phase              r_phase, n_phase;
    logic [7:0]          r_lit_left, n_lit_left;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic                r_fin, n_fin;
    logic [7:0]          r_count, n_count;
    logic [7:0]          r_color, n_color;
    logic                r_ovr, n_ovr;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [DIM_BITS-1:0] eff_w, eff_h;

    // decode path
    t_phase              p_phase;
    logic [7:0]          p_lit_left, lit_dec;
    logic [DIM_BITS-1:0] p_col, p_row, col1, row1;
    logic                p_fin, fin1;

    // span path
    logic [DIM_BITS-1:0] room, col_sum, row_inc;
    logic [7:0]          take;
    logic                end_row, frame_end;

    assign eff_w = (r_width < WIDTH_MIN) ? WIDTH_MIN : r_width;
    assign eff_h = (r_height == '0) ? DIM_BITS'(1) : r_height;

    always_comb begin
        p_phase    = i_in.frame_start ? PH_HEADER : r_phase;
        p_lit_left = i_in.frame_start ? 8'd0 : r_lit_left;
        p_col      = i_in.frame_start ? '0 : r_col;
        p_row      = i_in.frame_start ? '0 : r_row;
        p_fin      = i_in.frame_start ? 1'b0 : r_fin;
        // wrap left over from a width change
        if (!p_fin && p_col >= eff_w) begin
            col1 = '0;
            row1 = p_row + DIM_BITS'(1);
        end else begin
            col1 = p_col;
            row1 = p_row;
        end
        fin1    = p_fin | (row1 >= eff_h);
        lit_dec = p_lit_left - 8'd1;
    end

    always_comb begin
        room    = eff_w - r_col;
        take    = ({{(DIM_BITS-8){1'b0}}, r_count} < room) ? r_count : room[7:0];
        col_sum = r_col + {{(DIM_BITS-8){1'b0}}, take};
        end_row = (col_sum >= eff_w);
        row_inc = r_row + DIM_BITS'(1);
        frame_end = end_row && (row_inc >= eff_h);
    end

    assign o_status.pending   = r_ovr | (r_count != 8'd0);
    assign o_status.span_last = r_ovr | (r_count == take) | frame_end;
    assign o_status.out_free  = !r_out_valid | i_out_ready;

    always_comb begin
        n_phase     = r_phase;
        n_lit_left  = r_lit_left;
        n_col       = r_col;
        n_row       = r_row;
        n_fin       = r_fin;
        n_count     = r_count;
        n_color     = r_color;
        n_ovr       = r_ovr;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cmd.accept) begin
            n_col      = col1;
            n_row      = row1;
            n_fin      = fin1;
            n_phase    = p_phase;
            n_lit_left = p_lit_left;
            n_ovr      = fin1;
            n_count    = 8'd0;
            n_color    = i_in.body_byte;
            if (!fin1) begin
                if (!r_packed) begin
                    n_count = 8'd1;
                end else begin
                    case (p_phase)
                        PH_LITERAL: begin
                            n_count    = 8'd1;
                            n_lit_left = lit_dec;
                            if (lit_dec == 8'd0) begin
                                n_phase = PH_HEADER;
                            end
                        end
                        PH_REPEAT: begin
                            n_count    = p_lit_left;
                            n_lit_left = 8'd0;
                            n_phase    = PH_HEADER;
                        end
                        default: begin
                            if (i_in.body_byte < NOOP_HEADER) begin
                                n_lit_left = i_in.body_byte + 8'd1;
                                n_phase    = PH_LITERAL;
                            end else if (i_in.body_byte > NOOP_HEADER) begin
                                n_lit_left = 8'(9'd257 - {1'b0, i_in.body_byte});
                                n_phase    = PH_REPEAT;
                            end else begin
                                n_phase = PH_HEADER;
                            end
                        end
                    endcase
                end
            end
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (r_ovr) begin
                n_out.overrun      = 1'b1;
                n_out.last_of_item = 1'b1;
                n_ovr              = 1'b0;
            end else begin
                n_out.color        = r_color;
                n_out.span_x       = r_col;
                n_out.span_row     = r_row;
                n_out.span_length  = take;
                n_out.last_of_item = o_status.span_last;
                n_count            = r_count - take;
                if (end_row) begin
                    n_col = '0;
                    n_row = row_inc;
                    if (frame_end) begin
                        n_fin            = 1'b1;
                        n_count          = 8'd0;
                        n_out.frame_done = 1'b1;
                    end
                end else begin
                    n_col = col_sum;
                end
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_packed    <= 1'b1;
            r_phase     <= PH_HEADER;
            r_lit_left  <= 8'd0;
            r_col       <= '0;
            r_row       <= '0;
            r_fin       <= 1'b0;
            r_count     <= 8'd0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    CFG_PACKED_MODE:  r_packed <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_col       <= n_col;
            r_row       <= n_row;
            r_fin       <= n_fin;
            r_count     <= n_count;
            r_ovr       <= n_ovr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_overrun_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.overrun |-> r_out.last_of_item)
        else $error("overrun result not marked last of item");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_done |-> r_out.last_of_item)
        else $error("frame end span not marked last of item");

    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && !r_ovr |-> take != 8'd0)
        else $error("empty span emitted");

    a_literal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LITERAL |-> r_lit_left != 8'd0)
        else $error("literal phase with no bytes left");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbsd_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AFTER  = 60;    // bytes taken before the long output stall
    localparam int HOLD_CYCLES = 250;
    localparam int SETTLE      = 8;     // lets a trailing header byte finish
    localparam int MAX_SPANS   = 34;

    // clock, reset and dut ports; the driven ones known from time zero
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    o_in_ready;
    t_in_item                in_item     = '0;
    logic                    o_out_valid;
    logic                    out_ready   = 1'b0;
    t_out_item               o_out;
    logic                    cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index   = '0;
    logic [DIM_BITS-1:0]     cfg_data    = '0;

    // stimulus and checking bookkeeping
    t_in_item    byte_backlog[$];     // body bytes waiting to be offered
    t_out_item   owed_spans[$];       // spans predicted but not yet seen
    int unsigned bytes_taken = 0;
    int unsigned in_gap      = 0;
    int unsigned out_gap     = 0;
    int unsigned hold_left   = 0;
    logic        hold_done   = 1'b0;
    logic        no_idle     = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    // predictor copy of the registers
    logic [DIM_BITS-1:0] reg_width  = WIDTH_RESET;
    logic [DIM_BITS-1:0] reg_height = HEIGHT_RESET;
    logic                reg_packed = 1'b1;

    // predictor copy of the decoder state
    t_phase              pk_phase   = PH_HEADER;
    logic [7:0]          pk_count   = '0;
    logic [DIM_BITS-1:0] pos_col    = '0;
    logic [DIM_BITS-1:0] pos_row    = '0;
    logic                frame_full = 1'b0;

    // widths below the minimum act as the minimum, a zero height as one row
    function automatic int unsigned active_width();
        return (reg_width < WIDTH_MIN) ? int'(WIDTH_MIN) : int'(reg_width);
    endfunction

    function automatic int unsigned active_height();
        return (reg_height == '0) ? 1 : int'(reg_height);
    endfunction

    // lay count pixels of one color, one span per row piece
    function automatic int paint_run(logic [7:0] color, int unsigned count);
        int unsigned w, h, room, take;
        int          placed;
        t_out_item   s;
        w      = active_width();
        h      = active_height();
        placed = 0;
        while (count > 0 && !frame_full && placed < MAX_SPANS) begin
            room          = w - pos_col;
            take          = (count < room) ? count : room;
            s             = '0;
            s.color       = color;
            s.span_x      = pos_col;
            s.span_row    = pos_row;
            s.span_length = take[7:0];
            count         = count - take;
            pos_col       = pos_col + take[DIM_BITS-1:0];
            if (pos_col >= w) begin
                // row end: wrap, and the last row closes the frame
                pos_col = '0;
                pos_row = pos_row + 1'b1;
                if (pos_row >= h) begin
                    frame_full   = 1'b1;
                    s.frame_done = 1'b1;
                end
            end
            owed_spans.push_back(s);
            placed++;
        end
        return placed;
    endfunction

    // work out the spans one accepted body byte causes
    function automatic void decode_byte(t_in_item it);
        int        placed;
        int        run_len;
        t_out_item s;
        placed = 0;
        if (it.frame_start) begin
            pk_phase   = PH_HEADER;
            pk_count   = '0;
            pos_col    = '0;
            pos_row    = '0;
            frame_full = 1'b0;
        end
        // registers may have shrunk under the current position
        if (!frame_full && pos_col >= active_width()) begin
            pos_col = '0;
            pos_row = pos_row + 1'b1;
        end
        if (!frame_full && pos_row >= active_height())
            frame_full = 1'b1;
        if (frame_full) begin
            // byte past the frame: a lone overrun marker
            s              = '0;
            s.last_of_item = 1'b1;
            s.overrun      = 1'b1;
            owed_spans.push_back(s);
            return;
        end
        if (!reg_packed) begin
            placed = paint_run(it.body_byte, 1);
        end else begin
            case (pk_phase)
                PH_LITERAL: begin
                    placed   = paint_run(it.body_byte, 1);
                    pk_count = pk_count - 8'd1;
                    if (pk_count == '0)
                        pk_phase = PH_HEADER;
                end
                PH_REPEAT: begin
                    placed   = paint_run(it.body_byte, pk_count);
                    pk_count = '0;
                    pk_phase = PH_HEADER;
                end
                default: begin
                    if (it.body_byte < NOOP_HEADER) begin
                        pk_count = it.body_byte + 8'd1;
                        pk_phase = PH_LITERAL;
                    end else if (it.body_byte > NOOP_HEADER) begin
                        run_len  = 257 - int'(it.body_byte);
                        pk_count = run_len[7:0];
                        pk_phase = PH_REPEAT;
                    end else begin
                        pk_phase = PH_HEADER;
                    end
                end
            endcase
        end
        if (placed > 0)
            owed_spans[owed_spans.size()-1].last_of_item = 1'b1;
    endfunction

    function automatic void offer(logic [7:0] b, logic fs);
        t_in_item it;
        it.body_byte   = b;
        it.frame_start = fs;
        byte_backlog.push_back(it);
    endfunction

    // mostly well formed packets with random content, some stray bytes
    function automatic void queue_random_body(int unsigned n_items, int unsigned start_one_in);
        int unsigned queued, len, kind, i;
        logic        fs;
        queued = 0;
        while (queued < n_items) begin
            fs   = ($urandom_range(1, start_one_in) == 1);
            kind = $urandom_range(0, 19);
            if (!reg_packed) begin
                offer(8'($urandom_range(0, 255)), fs);
                queued++;
            end else if (kind < 8) begin
                // literal packet, now and then a long one
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(8, 127)
                                                   : $urandom_range(0, 7);
                offer(len[7:0], fs);
                queued++;
                for (i = 0; i <= len; i++) begin
                    offer(8'($urandom_range(0, 255)), 1'b0);
                    queued++;
                end
            end else if (kind < 15) begin
                // repeat packet
                offer(8'($urandom_range(129, 255)), fs);
                offer(8'($urandom_range(0, 255)), 1'b0);
                queued += 2;
            end else if (kind < 16) begin
                offer(NOOP_HEADER, fs);
                queued++;
            end else begin
                // stray byte, may cut a packet or restart the frame
                offer(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                queued++;
            end
        end
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_span(t_out_item got);
        t_out_item want;
        if (owed_spans.size() == 0) begin
            $display("%0t: span expected none actual color %0d x %0d row %0d len %0d ovr %0d",
                     $time, got.color, got.span_x, got.span_row, got.span_length, got.overrun);
            fail_count++;
            return;
        end
        want = owed_spans.pop_front();
        compare_field("color", 16'(want.color), 16'(got.color));
        compare_field("span_x", 16'(want.span_x), 16'(got.span_x));
        compare_field("span_row", 16'(want.span_row), 16'(got.span_row));
        compare_field("span_length", 16'(want.span_length), 16'(got.span_length));
        compare_field("last_of_item", 16'(want.last_of_item), 16'(got.last_of_item));
        compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        compare_field("overrun", 16'(want.overrun), 16'(got.overrun));
    endfunction

    packbits_pixel_span_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // byte driver: predicts on acceptance, then offers the next item or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                decode_byte(in_item);
                bytes_taken <= bytes_taken + 1;
            end
            // payload only moves once the current item is gone
            if (!in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (byte_backlog.size() != 0) begin
                    in_item  <= byte_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 4) == 0)
                        in_gap = $urandom_range(1, 8);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // one long output stall so the block backs up into its input
    always @(posedge i_clk) begin
        if (!hold_done && bytes_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // span monitor: checks each accepted span, idles the ready in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready)
                check_span(o_out);
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (out_gap != 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    out_gap = $urandom_range(1, 8);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("packbits_pixel_span_decoder: mismatch");
            $finish;
        end
    end

    // everything offered, taken and seen, plus time for a trailing header
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (byte_backlog.size() != 0 || in_valid || owed_spans.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = val;
            CFG_IMAGE_HEIGHT: reg_height = val;
            CFG_PACKED_MODE:  reg_packed = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(int unsigned w, int unsigned h, logic packed_body);
        write_reg(CFG_IMAGE_WIDTH, w[DIM_BITS-1:0]);
        write_reg(CFG_IMAGE_HEIGHT, h[DIM_BITS-1:0]);
        write_reg(CFG_PACKED_MODE, {{(DIM_BITS-1){1'b0}}, packed_body});
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes: a full 128 run on row 0, then a no-op
        offer(8'h81, 1'b1);
        offer(8'hC3, 1'b0);
        offer(NOOP_HEADER, 1'b0);
        wait_drained();

        // 4 x 3 raster: a run cut off by the frame end, then an overrun
        write_all(4, 3, 1'b1);
        offer(8'h81, 1'b1);
        offer(8'h3C, 1'b0);
        offer(8'h00, 1'b0);
        // fresh frame: short repeat, two-byte literal, no-op, open literal
        offer(8'hFF, 1'b1);
        offer(8'hAA, 1'b0);
        offer(8'h01, 1'b0);
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b0);
        offer(NOOP_HEADER, 1'b0);
        offer(8'h05, 1'b0);
        offer(8'h11, 1'b0);
        offer(8'h22, 1'b0);
        wait_drained();

        // drop to raw pixels in the middle of the literal, then resume it
        write_reg(CFG_PACKED_MODE, '0);
        offer(NOOP_HEADER, 1'b0);
        offer(8'h81, 1'b0);
        wait_drained();
        write_reg(CFG_PACKED_MODE, 12'd1);
        offer(8'h33, 1'b0);
        offer(8'h44, 1'b0);
        offer(8'h55, 1'b0);
        offer(8'h66, 1'b0);
        wait_drained();

        // shrink under the position: wrap forces the frame closed
        write_all(8, 2, 1'b1);
        offer(8'hFD, 1'b1);
        offer(8'h77, 1'b0);
        wait_drained();
        write_all(2, 0, 1'b1);
        offer(8'h10, 1'b0);
        offer(8'h81, 1'b1);
        offer(8'h99, 1'b0);
        wait_drained();

        // random body under several raster settings, largest first
        write_all(4095, 4095, 1'b1);
        queue_random_body(24, 20);
        wait_drained();

        write_all(4, 1, 1'b1);
        queue_random_body(24, 3);
        wait_drained();

        write_all($urandom_range(4, 40), $urandom_range(1, 6), 1'b0);
        queue_random_body(24, 8);
        wait_drained();

        write_all(0, 4095, 1'b1);
        queue_random_body(24, 10);
        wait_drained();

        // last stretch at full rate on both sides
        no_idle = 1'b1;
        write_all($urandom_range(5, 300), $urandom_range(1, 20), 1'b1);
        queue_random_body(24, 6);
        wait_drained();

        repeat (4 * SETTLE) @(negedge i_clk);
        if (fail_count == 0)
            $display("packbits_pixel_span_decoder: match");
        else
            $display("packbits_pixel_span_decoder: mismatch");
        $finish;
    end

endmodule
